// ===== rtl/hnre_pkg.sv =====
package hnre_pkg;

  // store geometry
  localparam int TREE_LEVELS  = 10;
  localparam int STORE_DEPTH  = 1 << TREE_LEVELS;
  localparam int ADDR_W       = TREE_LEVELS;

  // item fields
  localparam int NODE_INDEX_W = 10;
  localparam int VALUE_W      = 31;
  localparam int STATUS_W     = 2;
  localparam int COMMAND_W    = 1;

  // walk pointer holds any node index a command can name, or any store index
  localparam int CUR_W = (TREE_LEVELS > NODE_INDEX_W) ? TREE_LEVELS : NODE_INDEX_W;

  // configuration
  localparam int KEEP_W       = 4;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;
  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(1);

  typedef enum logic [COMMAND_W-1:0] {
    CMD_WRITE  = 1'b0,
    CMD_REMOVE = 1'b1
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_WRITTEN = 2'd0,
    STAT_REMOVED = 2'd1,
    STAT_REFUSED = 2'd2
  } status_t;

  // register index decoded from paddr[APB_ADDR_W-1:2]
  localparam logic [APB_ADDR_W-3:0] REG_KEEP_LEVELS = '0;

endpackage

// ===== rtl/hnre_channels.sv =====
interface hnre_in_if;
  logic                              valid;
  logic                              ready;
  logic [hnre_pkg::COMMAND_W-1:0]    command;
  logic [hnre_pkg::NODE_INDEX_W-1:0] node_index;
  logic [hnre_pkg::VALUE_W-1:0]      node_value;

  modport source (output valid, command, node_index, node_value, input ready);
  modport sink   (input valid, command, node_index, node_value, output ready);
endinterface

interface hnre_out_if;
  logic                          valid;
  logic                          ready;
  logic [hnre_pkg::STATUS_W-1:0] status;
  logic [hnre_pkg::VALUE_W-1:0]  removed_value;

  modport source (output valid, status, removed_value, input ready);
  modport sink   (input valid, status, removed_value, output ready);
endinterface

// ===== rtl/heap_node_removal_engine_core.sv =====
// Channel   | Dir | Handshake        | Payload
// ----------+-----+------------------+-------------------------------------------
// in_item   | in  | valid/ready      | command, node_index, node_value
// out_item  | out | valid/ready      | status, removed_value
// APB cfg   | in  | psel/penable     | keep_levels at byte address 0
//
// Sequence: a write goes straight to the response. A removal loads the target,
//   then walks down to a leaf (the check walk) and, if allowed on an occupied
//   node, walks the same path again to delete; one store level per cycle,
//   set by the registered read data of the heap store.
// Reset: synchronous, active low; then a clearing pass that zeroes all STORE_DEPTH entries.
// Stalls: one item in flight; the next item is taken while a result waits.
module heap_node_removal_engine_core (
  input  logic                              clk,
  input  logic                              rst_n,
  hnre_in_if.sink                           in_item,
  hnre_out_if.source                        out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hnre_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [hnre_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [hnre_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int ADDR_W  = hnre_pkg::ADDR_W;
  localparam int CUR_W   = hnre_pkg::CUR_W;
  localparam int VALUE_W = hnre_pkg::VALUE_W;
  localparam int KEEP_W  = hnre_pkg::KEEP_W;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_LOAD   = 6'b000100,
    ST_CHECK  = 6'b001000,
    ST_DELETE = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [KEEP_W-1:0] keep_r;
  logic              cfg_wr;
  logic              cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[hnre_pkg::APB_ADDR_W-1:2] == hnre_pkg::REG_KEEP_LEVELS);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? hnre_pkg::APB_DATA_W'(keep_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= hnre_pkg::KEEP_RESET;
    end else if (cfg_wr) begin
      keep_r <= pwdata[KEEP_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Heap store: one write port, two read ports, registered read data
  // ---------------------------------------------------------------------
  logic [VALUE_W-1:0] heap_mem [hnre_pkg::STORE_DEPTH];
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr_a;
  logic [ADDR_W-1:0]  rd_addr_b;
  logic [VALUE_W-1:0] rd_a_r;
  logic [VALUE_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= heap_mem[rd_addr_a];
      rd_b_r <= heap_mem[rd_addr_b];
    end
  end

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic [CUR_W-1:0]   cur_r, cur_nxt;       // node being walked
  logic [CUR_W-1:0]   tgt_r, tgt_nxt;       // removal target
  logic [VALUE_W-1:0] taken_r, taken_nxt;   // target value before removal
  logic               oor_r, oor_nxt;       // last read lay beyond the store
  logic [hnre_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]            res_value_r, res_value_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [hnre_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]            out_value_r, out_value_nxt;

  // read issue: either a node itself or both of its children
  logic             rd_self;
  logic [CUR_W-1:0] rd_node;

  // walk step on the returned children
  logic [VALUE_W-1:0] left_val, right_val, max_val;
  logic               is_leaf, go_left;
  logic [CUR_W-1:0]   child_idx;
  logic [CUR_W-1:0]   in_idx;
  logic               in_in_store;
  logic               in_acc;
  logic               out_free;

  assign left_val  = oor_r ? '0 : rd_a_r;
  assign right_val = oor_r ? '0 : rd_b_r;
  assign is_leaf   = (left_val == '0) && (right_val == '0);
  assign go_left   = left_val > right_val;   // tie goes right
  assign max_val   = go_left ? left_val : right_val;
  // only used when not a leaf, so the children lie inside the store
  assign child_idx = {cur_r[CUR_W-2:0], !go_left};

  assign rd_addr_a = rd_self ? ADDR_W'(rd_node) : ADDR_W'({rd_node, 1'b0});
  assign rd_addr_b = ADDR_W'({rd_node, 1'b1});

  assign in_idx      = CUR_W'(in_item.node_index);
  assign in_in_store = (in_idx >> hnre_pkg::TREE_LEVELS) == '0;
  assign in_item.ready = (state_r == ST_IDLE);
  assign in_acc        = in_item.valid && in_item.ready;
  assign out_free      = !out_valid_r || out_item.ready;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cur_nxt        = cur_r;
    tgt_nxt        = tgt_r;
    taken_nxt      = taken_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    wr_en          = 1'b0;
    wr_addr        = ADDR_W'(cur_r);
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_self        = 1'b0;
    rd_node        = cur_r;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(hnre_pkg::STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_value_nxt = '0;
          if (in_item.command == hnre_pkg::CMD_WRITE) begin
            // node 0 and nodes beyond the store are not written
            wr_en          = (in_idx != '0) && in_in_store;
            wr_addr        = ADDR_W'(in_idx);
            wr_data        = in_item.node_value;
            res_status_nxt = hnre_pkg::STAT_WRITTEN;
            state_nxt      = ST_RESP;
          end else if (in_idx == '0) begin
            res_status_nxt = hnre_pkg::STAT_REFUSED;
            state_nxt      = ST_RESP;
          end else begin
            rd_en     = 1'b1;
            rd_self   = 1'b1;
            rd_node   = in_idx;
            cur_nxt   = in_idx;
            tgt_nxt   = in_idx;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        taken_nxt = oor_r ? '0 : rd_a_r;
        rd_en     = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (is_leaf) begin
          if ((cur_r >> keep_r) == '0) begin
            res_status_nxt = hnre_pkg::STAT_REFUSED;
            res_value_nxt  = '0;
            state_nxt      = ST_RESP;
          end else if (taken_r == '0) begin
            // empty target: reported removed, store untouched
            res_status_nxt = hnre_pkg::STAT_REMOVED;
            res_value_nxt  = '0;
            state_nxt      = ST_RESP;
          end else begin
            rd_en     = 1'b1;
            rd_node   = tgt_r;
            cur_nxt   = tgt_r;
            state_nxt = ST_DELETE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_node = child_idx;
          cur_nxt = child_idx;
        end
      end
      ST_DELETE: begin
        // pull the larger child up; the writes trail the reads down the path
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(cur_r);
        wr_data = is_leaf ? '0 : max_val;
        if (is_leaf) begin
          res_status_nxt = hnre_pkg::STAT_REMOVED;
          res_value_nxt  = taken_r;
          state_nxt      = ST_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_node = child_idx;
          cur_nxt = child_idx;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // out-of-store flag for whatever the read port fetches this cycle
  assign oor_nxt = rd_self ? ((rd_node >> hnre_pkg::TREE_LEVELS) != '0)
                           : ((rd_node >> (hnre_pkg::TREE_LEVELS - 1)) != '0);

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    if (out_valid_r && out_item.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_RESP && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_value_nxt  = res_value_r;
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.status        = out_status_r;
  assign out_item.removed_value = out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    tgt_r        <= tgt_nxt;
    taken_r      <= taken_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    if (rd_en) begin
      oor_r <= oor_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // the delete walk only starts on an occupied target
  a_delete_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DELETE |-> taken_r != '0)
    else $error("delete walk on empty target");

  // node 0 is never written once the clearing pass is over
  a_no_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r != ST_CLEAR) |-> wr_addr != '0)
    else $error("write to node 0");

  // each walk step moves strictly deeper
  a_walk_descends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CHECK || state_r == ST_DELETE) && !is_leaf)
      |=> cur_r > $past(cur_r))
    else $error("walk did not descend");

  // a result is loaded only when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item.ready) |=> $stable(out_value_r) && $stable(out_status_r))
    else $error("pending result overwritten");

endmodule
